@@ sv/aco_ptu_pkg.sv @@
// shared types and constants of the pheromone table update block
// no dependencies
package aco_ptu_pkg;

  localparam int ENTRY_W = 32;
  localparam int RATE_W = 16;
  localparam int FRAC_W = 16;
  localparam int NODE_IN_W = 6;
  localparam int KIND_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // numerator c*q*2^16 with c up to 7, denominator 10*cost
  localparam int NUM_W = 51;
  localparam int DEN_W = 36;
  localparam int DIV_CNT_W = 6;

  localparam logic [ENTRY_W-1:0] ENTRY_RESET = 32'h0001_0000;
  localparam logic [ENTRY_W-1:0] ENTRY_SAT = 32'hFFFF_FFFF;

  localparam logic [RATE_W-1:0] RATE_RESET = 16'd6554;
  localparam logic [ENTRY_W-1:0] SCALE_RESET = 32'd65536;
  localparam logic [ENTRY_W-1:0] TMIN_RESET = 32'd655;
  localparam logic [ENTRY_W-1:0] TMAX_RESET = 32'd1048576;
  localparam logic [ENTRY_W-1:0] TINIT_RESET = 32'd65536;
  localparam logic [NODE_IN_W-1:0] HNODE_RESET = 6'd63;

  localparam logic [KIND_W-1:0] KIND_EVAP = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DEP_ITER = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DEP_GLOB = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLAMP = 3'd3;
  localparam logic [KIND_W-1:0] KIND_BLEND = 3'd4;
  localparam logic [KIND_W-1:0] KIND_READ = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_RATE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TMIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TMAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TINIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HNODE = 3'd5;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SW_RD,
    S_SW_CALC,
    S_SW_WR,
    S_DIV,
    S_DP_RD,
    S_DP_ADD,
    S_DP_WR,
    S_FIN_RD,
    S_FIN_WAIT,
    S_DONE
  } state_t;

endpackage

@@ sv/aco_ptu_mem.sv @@
// pheromone table storage: one write port, one registered read port
// depends on aco_ptu_pkg
module aco_ptu_mem #(
  parameter int DEPTH = 4096,
  parameter int AW = 12
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [AW-1:0]                     waddr,
  input  logic [aco_ptu_pkg::ENTRY_W-1:0]   wdata,
  input  logic                              re,
  input  logic [AW-1:0]                     raddr,
  output logic [aco_ptu_pkg::ENTRY_W-1:0]   rdata
);

  logic [aco_ptu_pkg::ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/aco_ptu_div.sv @@
// restoring divider, one quotient bit per cycle, result saturated to 32 bits
// depends on aco_ptu_pkg
module aco_ptu_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [aco_ptu_pkg::NUM_W-1:0]     num,
  input  logic [aco_ptu_pkg::DEN_W-1:0]     den,
  output logic                              done,
  output logic [aco_ptu_pkg::ENTRY_W-1:0]   quo
);

  localparam int NW = aco_ptu_pkg::NUM_W;
  localparam int DW = aco_ptu_pkg::DEN_W;
  localparam int CW = aco_ptu_pkg::DIV_CNT_W;
  localparam int EW = aco_ptu_pkg::ENTRY_W;

  logic          running;
  logic [CW-1:0] cnt;
  logic [NW-1:0] q_sh;
  logic [DW-1:0] den_q;
  logic [DW-1:0] rem;
  logic [DW:0]   rem_sh;
  logic          fits;

  assign rem_sh = {rem, q_sh[NW-1]};
  assign fits = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder stays below den, so it fits in DW bits after the subtract
  always_ff @(posedge clk) begin
    if (start) begin
      q_sh <= num;
      den_q <= den;
      rem <= '0;
    end else if (running) begin
      q_sh <= {q_sh[NW-2:0], fits};
      if (fits) begin
        rem <= DW'(rem_sh - {1'b0, den_q});
      end else begin
        rem <= rem_sh[DW-1:0];
      end
    end
  end

  assign quo = (q_sh[NW-1:EW] != '0) ? aco_ptu_pkg::ENTRY_SAT : q_sh[EW-1:0];

endmodule

@@ sv/aco_pheromone_table_update.sv @@
// max-min ant system pheromone table: top level with command sequencer
// depends on aco_ptu_pkg, aco_ptu_mem, aco_ptu_div
//
// Usage: drive kind, node_a, node_b, route_cost with start high; the command
// is taken at a clock edge where busy is low. Exactly one result follows:
// done is high for one cycle with value and error, and the receiver must
// take it then. busy stays high from acceptance until done.
// Configuration is a plain write port (cfg_write, cfg_index, cfg_data). The
// user is to write it only while the block is idle; the block itself does not
// enforce this. Indexes beyond the list are ignored.
// A sweep (evaporate, clamp, reset blend) reads, computes and writes back
// each off-diagonal entry of the active square in turn and skips the
// diagonal. A deposit runs the serial divider, then two read-modify-writes
// (a,b then b,a) and a read-back of (a,b); a read reads (a,b) back alone.
// After rst the table is cleared to 1.0 by a pass that writes all
// MAX_NODES*MAX_NODES entries (4096 by default); busy is high during that
// pass.
module aco_pheromone_table_update #(
  parameter int MAX_NODES = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [aco_ptu_pkg::KIND_W-1:0]        kind,
  input  logic [aco_ptu_pkg::NODE_IN_W-1:0]     node_a,
  input  logic [aco_ptu_pkg::NODE_IN_W-1:0]     node_b,
  input  logic [aco_ptu_pkg::ENTRY_W-1:0]       route_cost,
  output logic                                  done,
  output logic [aco_ptu_pkg::ENTRY_W-1:0]       value,
  output logic                                  error,
  input  logic                                  cfg_write,
  input  logic [aco_ptu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [aco_ptu_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int DEPTH = MAX_NODES * MAX_NODES;
  localparam int AW = $clog2(DEPTH);
  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int EW = aco_ptu_pkg::ENTRY_W;
  localparam int RW = aco_ptu_pkg::RATE_W;
  localparam int FW = aco_ptu_pkg::FRAC_W;
  localparam int NW = aco_ptu_pkg::NUM_W;
  localparam int DW = aco_ptu_pkg::DEN_W;
  localparam int PW = EW + RW + 1;

  aco_ptu_pkg::state_t state, state_next;

  logic [RW-1:0] evaporation_rate;
  logic [EW-1:0] deposit_scale, tau_min, tau_max, tau_initial;
  logic [aco_ptu_pkg::NODE_IN_W-1:0] highest_node;

  logic [aco_ptu_pkg::KIND_W-1:0] kind_q;
  logic [NODE_W-1:0] a_q, b_q, i_q, j_q;
  logic              second;
  logic [AW-1:0]     clr_cnt;
  logic [EW-1:0]     dep_q, res_q, value_q;
  logic [PW-1:0]     prod_q;
  logic              error_q;

  logic [8:0]        lim9;
  logic [NODE_W-1:0] last_node;
  logic              accept, bad_idx, req_err, is_sweep, is_dep;
  logic              sweep_last, diag;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata, rdata;
  logic [AW-1:0] addr_ij, addr_ab, addr_ba;

  logic            div_start, div_done;
  logic [NW-1:0]   div_num;
  logic [DW-1:0]   div_den;
  logic [EW-1:0]   div_quo;
  logic [EW+2:0]   cq;
  logic [RW:0]     keep;
  logic [EW:0]     sum_sat, sum_blend;

  // active square ends at min(highest_node, MAX_NODES - 1)
  assign lim9 = (9'(highest_node) > 9'(MAX_NODES - 1)) ? 9'(MAX_NODES - 1)
                                                      : 9'(highest_node);
  assign last_node = NODE_W'(lim9);

  assign busy = (state != aco_ptu_pkg::S_IDLE);
  assign accept = start && !busy;
  assign is_sweep = (kind == aco_ptu_pkg::KIND_EVAP) || (kind == aco_ptu_pkg::KIND_CLAMP)
                    || (kind == aco_ptu_pkg::KIND_BLEND);
  assign is_dep = (kind == aco_ptu_pkg::KIND_DEP_ITER) || (kind == aco_ptu_pkg::KIND_DEP_GLOB);
  assign bad_idx = (9'(node_a) > lim9) || (9'(node_b) > lim9);
  assign req_err = (is_dep && (bad_idx || route_cost == '0))
                   || (kind == aco_ptu_pkg::KIND_READ && bad_idx);

  // 3*q or 7*q, then scaled by 2^16; 10*cost as 8*cost + 2*cost
  assign cq = (kind == aco_ptu_pkg::KIND_DEP_ITER)
              ? (EW+3)'({1'b0, deposit_scale, 1'b0}) + (EW+3)'(deposit_scale)
              : (EW+3)'({deposit_scale, 3'b000}) - (EW+3)'(deposit_scale);
  assign div_num = {cq, {FW{1'b0}}};
  assign div_den = DW'({route_cost, 3'b000}) + DW'({route_cost, 1'b0});
  assign div_start = accept && is_dep && !req_err;

  assign addr_ij = AW'(i_q) * AW'(MAX_NODES) + AW'(j_q);
  assign addr_ab = AW'(a_q) * AW'(MAX_NODES) + AW'(b_q);
  assign addr_ba = AW'(b_q) * AW'(MAX_NODES) + AW'(a_q);

  assign sweep_last = (i_q == last_node) && (j_q == last_node);
  assign diag = (i_q == j_q);

  assign keep = (RW+1)'(1 << RW) - (RW+1)'(evaporation_rate);
  assign sum_sat = {1'b0, rdata} + {1'b0, dep_q};
  assign sum_blend = {1'b0, rdata} + {1'b0, tau_initial};

  aco_ptu_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(rdata)
  );

  aco_ptu_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      aco_ptu_pkg::S_CLEAR: begin
        if (clr_cnt == AW'(DEPTH - 1)) begin
          state_next = aco_ptu_pkg::S_IDLE;
        end
      end
      aco_ptu_pkg::S_IDLE: begin
        if (accept) begin
          if (req_err) begin
            state_next = aco_ptu_pkg::S_DONE;
          end else if (is_sweep) begin
            state_next = aco_ptu_pkg::S_SW_RD;
          end else if (is_dep) begin
            state_next = aco_ptu_pkg::S_DIV;
          end else if (kind == aco_ptu_pkg::KIND_READ) begin
            state_next = aco_ptu_pkg::S_FIN_RD;
          end else begin
            state_next = aco_ptu_pkg::S_DONE;
          end
        end
      end
      aco_ptu_pkg::S_SW_RD: begin
        if (!diag) begin
          state_next = aco_ptu_pkg::S_SW_CALC;
        end else if (sweep_last) begin
          state_next = aco_ptu_pkg::S_DONE;
        end
      end
      aco_ptu_pkg::S_SW_CALC: state_next = aco_ptu_pkg::S_SW_WR;
      aco_ptu_pkg::S_SW_WR: begin
        state_next = sweep_last ? aco_ptu_pkg::S_DONE : aco_ptu_pkg::S_SW_RD;
      end
      aco_ptu_pkg::S_DIV: begin
        if (div_done) begin
          state_next = aco_ptu_pkg::S_DP_RD;
        end
      end
      aco_ptu_pkg::S_DP_RD: state_next = aco_ptu_pkg::S_DP_ADD;
      aco_ptu_pkg::S_DP_ADD: state_next = aco_ptu_pkg::S_DP_WR;
      aco_ptu_pkg::S_DP_WR: begin
        state_next = second ? aco_ptu_pkg::S_FIN_RD : aco_ptu_pkg::S_DP_RD;
      end
      aco_ptu_pkg::S_FIN_RD: state_next = aco_ptu_pkg::S_FIN_WAIT;
      aco_ptu_pkg::S_FIN_WAIT: state_next = aco_ptu_pkg::S_DONE;
      aco_ptu_pkg::S_DONE: state_next = aco_ptu_pkg::S_IDLE;
      default: state_next = aco_ptu_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = addr_ij;
    mem_wdata = res_q;
    mem_re = 1'b0;
    mem_raddr = addr_ij;
    unique case (state)
      aco_ptu_pkg::S_CLEAR: begin
        mem_we = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = aco_ptu_pkg::ENTRY_RESET;
      end
      aco_ptu_pkg::S_SW_RD: mem_re = !diag;
      aco_ptu_pkg::S_SW_WR: begin
        mem_we = 1'b1;
        if (kind_q == aco_ptu_pkg::KIND_EVAP) begin
          mem_wdata = prod_q[FW+EW-1:FW];
        end
      end
      aco_ptu_pkg::S_DP_RD: begin
        mem_re = 1'b1;
        mem_raddr = second ? addr_ba : addr_ab;
      end
      aco_ptu_pkg::S_DP_WR: begin
        mem_we = 1'b1;
        mem_waddr = second ? addr_ba : addr_ab;
      end
      aco_ptu_pkg::S_FIN_RD: begin
        mem_re = 1'b1;
        mem_raddr = addr_ab;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aco_ptu_pkg::S_CLEAR;
      clr_cnt <= '0;
      evaporation_rate <= aco_ptu_pkg::RATE_RESET;
      deposit_scale <= aco_ptu_pkg::SCALE_RESET;
      tau_min <= aco_ptu_pkg::TMIN_RESET;
      tau_max <= aco_ptu_pkg::TMAX_RESET;
      tau_initial <= aco_ptu_pkg::TINIT_RESET;
      highest_node <= aco_ptu_pkg::HNODE_RESET;
    end else begin
      state <= state_next;
      if (state == aco_ptu_pkg::S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cfg_write) begin
        case (cfg_index)
          aco_ptu_pkg::CFG_RATE: evaporation_rate <= cfg_data[RW-1:0];
          aco_ptu_pkg::CFG_SCALE: deposit_scale <= cfg_data[EW-1:0];
          aco_ptu_pkg::CFG_TMIN: tau_min <= cfg_data[EW-1:0];
          aco_ptu_pkg::CFG_TMAX: tau_max <= cfg_data[EW-1:0];
          aco_ptu_pkg::CFG_TINIT: tau_initial <= cfg_data[EW-1:0];
          aco_ptu_pkg::CFG_HNODE: highest_node <= cfg_data[aco_ptu_pkg::NODE_IN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      aco_ptu_pkg::S_IDLE: begin
        if (accept) begin
          kind_q <= kind;
          a_q <= NODE_W'(node_a);
          b_q <= NODE_W'(node_b);
          i_q <= '0;
          j_q <= '0;
          second <= 1'b0;
          value_q <= '0;
          error_q <= req_err;
        end
      end
      aco_ptu_pkg::S_SW_RD: begin
        if (diag && !sweep_last) begin
          if (j_q == last_node) begin
            j_q <= '0;
            i_q <= i_q + 1'b1;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
      end
      aco_ptu_pkg::S_SW_CALC: begin
        prod_q <= PW'(rdata) * PW'(keep);
        // lower bound checked first when the bounds cross
        if (kind_q == aco_ptu_pkg::KIND_CLAMP) begin
          if (rdata < tau_min) begin
            res_q <= tau_min;
          end else if (rdata > tau_max) begin
            res_q <= tau_max;
          end else begin
            res_q <= rdata;
          end
        end else begin
          res_q <= sum_blend[EW:1];
        end
      end
      aco_ptu_pkg::S_SW_WR: begin
        if (!sweep_last) begin
          if (j_q == last_node) begin
            j_q <= '0;
            i_q <= i_q + 1'b1;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
      end
      aco_ptu_pkg::S_DIV: begin
        if (div_done) begin
          dep_q <= div_quo;
        end
      end
      aco_ptu_pkg::S_DP_ADD: begin
        res_q <= sum_sat[EW] ? aco_ptu_pkg::ENTRY_SAT : sum_sat[EW-1:0];
      end
      aco_ptu_pkg::S_DP_WR: second <= 1'b1;
      aco_ptu_pkg::S_FIN_WAIT: value_q <= rdata;
      default: begin
      end
    endcase
  end

  assign done = (state == aco_ptu_pkg::S_DONE);
  assign value = value_q;
  assign error = error_q;

endmodule

@@ dv/tb.sv @@
// testbench for aco_pheromone_table_update: directed and random commands
// checked against an in-bench pheromone table predictor; depends on aco_ptu_pkg
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 60000;
  localparam logic [aco_ptu_pkg::KIND_W-1:0] KIND_SPARE6 = 3'd6;
  localparam logic [aco_ptu_pkg::KIND_W-1:0] KIND_SPARE7 = 3'd7;
  localparam logic [aco_ptu_pkg::CFG_IDX_W-1:0] CFG_SPARE6 = 3'd6;
  localparam logic [aco_ptu_pkg::CFG_IDX_W-1:0] CFG_SPARE7 = 3'd7;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [aco_ptu_pkg::KIND_W-1:0] kind;
  logic [aco_ptu_pkg::NODE_IN_W-1:0] node_a;
  logic [aco_ptu_pkg::NODE_IN_W-1:0] node_b;
  logic [aco_ptu_pkg::ENTRY_W-1:0] route_cost;
  logic done;
  logic [aco_ptu_pkg::ENTRY_W-1:0] value;
  logic error;
  logic cfg_write;
  logic [aco_ptu_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [aco_ptu_pkg::CFG_DATA_W-1:0] cfg_data;

  aco_pheromone_table_update u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .node_a(node_a), .node_b(node_b), .route_cost(route_cost), .done(done),
    .value(value), .error(error), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predictor state
  logic [aco_ptu_pkg::ENTRY_W-1:0] pher [0:63][0:63];
  logic [aco_ptu_pkg::RATE_W-1:0] rho;
  logic [aco_ptu_pkg::ENTRY_W-1:0] q_scale;
  logic [aco_ptu_pkg::ENTRY_W-1:0] t_min;
  logic [aco_ptu_pkg::ENTRY_W-1:0] t_max;
  logic [aco_ptu_pkg::ENTRY_W-1:0] t_init;
  logic [aco_ptu_pkg::NODE_IN_W-1:0] top_node;

  logic [aco_ptu_pkg::ENTRY_W-1:0] want_value [$];
  logic want_error [$];
  int fails;
  int idle_cycles;
  bit no_gaps;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic table_sweep(input logic [aco_ptu_pkg::KIND_W-1:0] k);
    logic [63:0] t;
    for (int i = 0; i <= top_node; i++) begin
      for (int j = 0; j <= top_node; j++) begin
        if (i != j) begin
          t = {32'd0, pher[i][j]};
          if (k == aco_ptu_pkg::KIND_EVAP) t = (t * (64'd65536 - {48'd0, rho})) >> 16;
          else if (k == aco_ptu_pkg::KIND_CLAMP) begin
            if (t < {32'd0, t_min}) t = {32'd0, t_min};
            else if (t > {32'd0, t_max}) t = {32'd0, t_max};
          end else t = (t + {32'd0, t_init}) >> 1;
          pher[i][j] = t[31:0];
        end
      end
    end
  endtask

  function automatic logic [31:0] add_sat(input logic [31:0] x, input logic [31:0] y);
    logic [32:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[32] ? aco_ptu_pkg::ENTRY_SAT : s[31:0];
  endfunction

  task automatic predict_command(input logic [aco_ptu_pkg::KIND_W-1:0] k,
                                 input logic [5:0] a, input logic [5:0] b,
                                 input logic [31:0] cost);
    logic [31:0] v;
    logic e;
    logic [63:0] num;
    logic [63:0] dep;
    logic [31:0] d32;
    v = '0;
    e = 1'b0;
    if (k == aco_ptu_pkg::KIND_EVAP || k == aco_ptu_pkg::KIND_CLAMP
        || k == aco_ptu_pkg::KIND_BLEND) table_sweep(k);
    else if (k == aco_ptu_pkg::KIND_DEP_ITER || k == aco_ptu_pkg::KIND_DEP_GLOB
             || k == aco_ptu_pkg::KIND_READ) begin
      if (a > top_node || b > top_node || (k != aco_ptu_pkg::KIND_READ && cost == 0)) e = 1'b1;
      else begin
        if (k != aco_ptu_pkg::KIND_READ) begin
          num = ((k == aco_ptu_pkg::KIND_DEP_ITER) ? 64'd3 : 64'd7) * {32'd0, q_scale}
                * 64'd65536;
          dep = num / ({32'd0, cost} * 64'd10);
          d32 = (dep > 64'hFFFF_FFFF) ? aco_ptu_pkg::ENTRY_SAT : dep[31:0];
          pher[a][b] = add_sat(pher[a][b], d32);
          pher[b][a] = add_sat(pher[b][a], d32);
        end
        v = pher[a][b];
      end
    end
    want_value.push_back(v);
    want_error.push_back(e);
  endtask

  // one item; start is left high so back-to-back items need no extra edge
  task automatic send_cmd(input logic [aco_ptu_pkg::KIND_W-1:0] k, input logic [5:0] a,
                          input logic [5:0] b, input logic [31:0] cost);
    if (!no_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    start <= 1'b1;
    kind <= k;
    node_a <= a;
    node_b <= b;
    route_cost <= cost;
    do @(posedge clk); while (busy);
    predict_command(k, a, b, cost);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (want_value.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [aco_ptu_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      aco_ptu_pkg::CFG_RATE: rho = data[15:0];
      aco_ptu_pkg::CFG_SCALE: q_scale = data;
      aco_ptu_pkg::CFG_TMIN: t_min = data;
      aco_ptu_pkg::CFG_TMAX: t_max = data;
      aco_ptu_pkg::CFG_TINIT: t_init = data;
      aco_ptu_pkg::CFG_HNODE: top_node = data[5:0];
      default: ;
    endcase
  endtask

  task automatic end_writes;
    cfg_write <= 1'b0;
  endtask

  function automatic logic [31:0] pick32(input logic [31:0] typical);
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom();
      default: return typical;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (want_value.size() == 0) begin
        $error("result with no item pending: value %h error %b", value, error);
        fails++;
      end else begin
        if (value !== want_value[0]) begin
          $error("value mismatch: expected %h actual %h", want_value[0], value);
          fails++;
        end
        if (error !== want_error[0]) begin
          $error("error mismatch: expected %b actual %b", want_error[0], error);
          fails++;
        end
        void'(want_value.pop_front());
        void'(want_error.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic test_full_table;
    // default config, 64 nodes: one of each sweep plus edges at the corners
    send_cmd(aco_ptu_pkg::KIND_READ, 6'd0, 6'd63, 32'd0);
    send_cmd(aco_ptu_pkg::KIND_DEP_ITER, 6'd63, 6'd0, 32'h0001_0000);
    send_cmd(aco_ptu_pkg::KIND_DEP_GLOB, 6'd0, 6'd63, 32'h0000_8000);
    send_cmd(aco_ptu_pkg::KIND_EVAP, 6'd0, 6'd0, 32'd0);
    send_cmd(aco_ptu_pkg::KIND_CLAMP, 6'd63, 6'd63, 32'hFFFF_FFFF);
    send_cmd(aco_ptu_pkg::KIND_BLEND, 6'd5, 6'd9, 32'd7);
    send_cmd(aco_ptu_pkg::KIND_READ, 6'd63, 6'd0, 32'hFFFF_FFFF);
    send_cmd(aco_ptu_pkg::KIND_READ, 6'd63, 6'd63, 32'd0);
    drain();
  endtask

  task automatic test_special_cases;
    write_reg(aco_ptu_pkg::CFG_HNODE, 32'd3);
    write_reg(aco_ptu_pkg::CFG_SCALE, 32'hFFFF_FFFF);
    end_writes();
    send_cmd(aco_ptu_pkg::KIND_DEP_GLOB, 6'd1, 6'd2, 32'd1);  // saturating deposit
    send_cmd(aco_ptu_pkg::KIND_DEP_ITER, 6'd2, 6'd2, 32'd1);  // self edge
    send_cmd(aco_ptu_pkg::KIND_DEP_ITER, 6'd1, 6'd2, 32'd0);  // zero cost
    send_cmd(aco_ptu_pkg::KIND_DEP_GLOB, 6'd4, 6'd1, 32'd5);  // just out of range
    send_cmd(aco_ptu_pkg::KIND_READ, 6'd0, 6'd63, 32'd0);     // far out of range
    send_cmd(KIND_SPARE6, 6'd1, 6'd2, 32'd9);
    send_cmd(KIND_SPARE7, 6'd3, 6'd3, 32'd9);
    send_cmd(aco_ptu_pkg::KIND_READ, 6'd3, 6'd3, 32'd0);
    drain();
    write_reg(aco_ptu_pkg::CFG_TMIN, 32'h0004_0000);          // crossed bounds
    write_reg(aco_ptu_pkg::CFG_TMAX, 32'h0002_0000);
    write_reg(aco_ptu_pkg::CFG_RATE, 32'd65535);
    write_reg(aco_ptu_pkg::CFG_TINIT, 32'hFFFF_FFFF);
    write_reg(aco_ptu_pkg::CFG_HNODE, 32'd1);
    end_writes();
    send_cmd(aco_ptu_pkg::KIND_CLAMP, 6'd0, 6'd0, 32'd0);
    send_cmd(aco_ptu_pkg::KIND_READ, 6'd0, 6'd1, 32'd0);
    send_cmd(aco_ptu_pkg::KIND_EVAP, 6'd0, 6'd0, 32'd0);
    send_cmd(aco_ptu_pkg::KIND_BLEND, 6'd0, 6'd0, 32'd0);
    send_cmd(aco_ptu_pkg::KIND_READ, 6'd1, 6'd0, 32'd0);
    drain();
    write_reg(aco_ptu_pkg::CFG_RATE, 32'd0);
    write_reg(CFG_SPARE6, 32'hFFFF_FFFF);                     // index past the list
    write_reg(CFG_SPARE7, 32'd0);
    end_writes();
    send_cmd(aco_ptu_pkg::KIND_EVAP, 6'd0, 6'd0, 32'd0);
    send_cmd(aco_ptu_pkg::KIND_READ, 6'd0, 6'd1, 32'd0);
    drain();
  endtask

  task automatic test_random_phase(input int items, input bit wide);
    logic [aco_ptu_pkg::KIND_W-1:0] k;
    logic [5:0] a;
    logic [5:0] b;
    logic [31:0] cost;
    int r;
    write_reg(aco_ptu_pkg::CFG_RATE, pick32($urandom_range(0, 20000)));
    write_reg(aco_ptu_pkg::CFG_SCALE, pick32($urandom_range(1, 32'h0004_0000)));
    write_reg(aco_ptu_pkg::CFG_TMIN, pick32($urandom_range(0, 32'h0001_0000)));
    write_reg(aco_ptu_pkg::CFG_TMAX, pick32($urandom_range(32'h0001_0000, 32'h0100_0000)));
    write_reg(aco_ptu_pkg::CFG_TINIT, pick32($urandom_range(0, 32'h0002_0000)));
    write_reg(aco_ptu_pkg::CFG_HNODE, wide ? 32'd63 : $urandom_range(1, 7));
    end_writes();
    for (int n = 0; n < items; n++) begin
      r = $urandom_range(0, 99);
      if (r < 28) k = aco_ptu_pkg::KIND_DEP_ITER;
      else if (r < 54) k = aco_ptu_pkg::KIND_DEP_GLOB;
      else if (r < 80) k = aco_ptu_pkg::KIND_READ;
      else if (r < 95) k = wide ? aco_ptu_pkg::KIND_READ
                                : 3'($urandom_range(0, 1) ? aco_ptu_pkg::KIND_EVAP
                                                          : aco_ptu_pkg::KIND_CLAMP);
      else if (r < 97) k = wide ? aco_ptu_pkg::KIND_READ : aco_ptu_pkg::KIND_BLEND;
      else k = $urandom_range(0, 1) ? KIND_SPARE6 : KIND_SPARE7;
      if ($urandom_range(0, 9) == 0) begin
        a = 6'($urandom());
        b = 6'($urandom());
      end else begin
        a = 6'($urandom_range(0, top_node));
        b = 6'($urandom_range(0, top_node));
      end
      case ($urandom_range(0, 9))
        0: cost = 32'd0;
        1, 2: cost = $urandom();
        default: cost = $urandom_range(1, 32'h0100_0000);
      endcase
      send_cmd(k, a, b, cost);
    end
    drain();
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    kind <= '0;
    node_a <= '0;
    node_b <= '0;
    route_cost <= '0;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    fails = 0;
    idle_cycles = 0;
    no_gaps = 1'b0;
    for (int i = 0; i < 64; i++)
      for (int j = 0; j < 64; j++) pher[i][j] = aco_ptu_pkg::ENTRY_RESET;
    rho = aco_ptu_pkg::RATE_RESET;
    q_scale = aco_ptu_pkg::SCALE_RESET;
    t_min = aco_ptu_pkg::TMIN_RESET;
    t_max = aco_ptu_pkg::TMAX_RESET;
    t_init = aco_ptu_pkg::TINIT_RESET;
    top_node = aco_ptu_pkg::HNODE_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // table clearing pass after reset
    do @(posedge clk); while (busy);
    test_full_table();
    test_special_cases();
    test_random_phase(150, 1'b0);
    test_random_phase(150, 1'b0);
    test_random_phase(150, 1'b1);
    test_random_phase(150, 1'b0);
    test_random_phase(150, 1'b0);
    test_random_phase(150, 1'b0);
    no_gaps = 1'b1;
    test_random_phase(150, 1'b0);
    if (fails == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

@@ files.f @@
sv/aco_ptu_pkg.sv
sv/aco_ptu_mem.sv
sv/aco_ptu_div.sv
sv/aco_pheromone_table_update.sv
dv/tb.sv
